@@ hdl/sewm_pkg.sv @@
// types, constants and codes shared by the sensor edge waiter matcher
`default_nettype none
package sewm_pkg;

  localparam int SENSORS      = 80;
  localparam int WAITERS      = 128;
  localparam int REPORT_BYTES = 10;
  localparam int MASK_BITS    = 80;
  localparam int ID_W         = 7;
  localparam int SNS_W        = 7;
  localparam int IDX_W        = $clog2(WAITERS);
  localparam int CNT_W        = $clog2(WAITERS + 1);
  localparam int GRP          = 8;
  localparam int NGROUPS      = (WAITERS + GRP - 1) / GRP;

  localparam logic [1:0] FUNC_REPORT   = 2'd0;
  localparam logic [1:0] FUNC_REGISTER = 2'd1;
  localparam logic [1:0] FUNC_REMOVE   = 2'd2;

  localparam logic KIND_ACK   = 1'b0;
  localparam logic KIND_EVENT = 1'b1;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  byte_index;
    logic [7:0]  sensor_byte;
    logic [6:0]  waiter_id;
    logic [31:0] mask_word0;
    logic [31:0] mask_word1;
    logic [31:0] mask_word2;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [6:0] sensor_number;
    logic       woken_valid;
    logic [6:0] woken_waiter;
    logic       last;
  } out_item_t;

  // mask bit s is sensor s
  typedef struct packed {
    logic                 valid;
    logic [ID_W-1:0]      id;
    logic [0:MASK_BITS-1] mask;
  } cell_data_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

  typedef struct packed {
    logic             by_id;
    logic [ID_W-1:0]  key;
    logic [SNS_W-1:0] sensor;
  } search_t;

endpackage
`default_nettype wire

@@ hdl/sensor_edge_waiter_matcher.sv @@
// top level: report byte store, waiter chain, first-match search and result register
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall   in_data  (sewm_pkg::in_item_t)
//   out      output     out_valid / out_stall out_data (sewm_pkg::out_item_t)
//
// one item at a time, in_stall high until idle again; unused codes are dropped.
// register or remove: two-level registered first-match search over the cell chain,
// compaction, then register appends, remove acks. report byte: each rising sensor
// in range is searched and emitted in turn; ack if none rises or index out of range
// reset empties the chain and clears the stored report bytes
// a stalled result holds the block in its emit or ack state
`default_nettype none
module sensor_edge_waiter_matcher (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  sewm_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output sewm_pkg::out_item_t  out_data
);
  import sewm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_MA, S_MB, S_REM, S_APP, S_EMIT, S_ACK
  } state_t;

  state_t               state_r;
  logic [1:0]           mode_r;
  logic [ID_W-1:0]      key_r;
  logic [0:MASK_BITS-1] mask_r;
  logic [7:0]           prev_r [REPORT_BYTES];
  logic [7:0]           rise_r;
  logic [3:0]           idx_r;
  logic [SNS_W-1:0]     sensor_r;
  logic                 last_r;
  logic [CNT_W-1:0]     count_r;
  logic [NGROUPS-1:0]   grp_any_r;
  logic [2:0]           grp_lidx_r [NGROUPS];
  logic [ID_W-1:0]      grp_id_r [NGROUPS];
  logic [IDX_W-1:0]     win_r;
  logic                 found_r;
  logic [ID_W-1:0]      wid_r;
  logic                 out_valid_r;
  out_item_t            out_data_r;

  cell_data_t           cells [WAITERS];
  logic [NGROUPS*GRP-1:0] hits;
  logic [ID_W-1:0]      ids [NGROUPS*GRP];
  cell_ctl_t            ctl [WAITERS];
  search_t              srch;
  cell_data_t           load_d;
  logic                 out_free;

  assign srch   = '{by_id: (mode_r != FUNC_REPORT), key: key_r, sensor: sensor_r};
  assign load_d = '{valid: 1'b1, id: key_r, mask: mask_r};
  assign out_free = !out_valid_r || !out_stall;

  for (genvar i = 0; i < WAITERS; i++) begin : g_cell
    cell_data_t nbr;
    if (i == WAITERS - 1) begin : g_end
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cells[i+1];
    end
    assign ctl[i].shift = (state_r == S_REM) && found_r && (IDX_W'(i) >= win_r);
    assign ctl[i].load  = (state_r == S_APP) && (CNT_W'(i) == count_r);
    sewm_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl[i]),
      .nbr   (nbr),
      .load_d(load_d),
      .srch  (srch),
      .cur   (cells[i]),
      .hit   (hits[i])
    );
    assign ids[i] = cells[i].id;
  end
  for (genvar i = WAITERS; i < NGROUPS * GRP; i++) begin : g_pad
    assign hits[i] = 1'b0;
    assign ids[i]  = '0;
  end

  // first-match encoder, first level
  logic             g_any  [NGROUPS];
  logic [2:0]       g_lidx [NGROUPS];
  logic [ID_W-1:0]  g_id   [NGROUPS];
  always_comb begin
    for (int g = 0; g < NGROUPS; g++) begin
      g_any[g]  = 1'b0;
      g_lidx[g] = '0;
      g_id[g]   = '0;
      for (int k = GRP - 1; k >= 0; k--) begin
        if (hits[g*GRP+k]) begin
          g_any[g]  = 1'b1;
          g_lidx[g] = 3'(k);
          g_id[g]   = ids[g*GRP+k];
        end
      end
    end
  end

  // first-match encoder, second level
  logic             b_found;
  logic [IDX_W-1:0] b_win;
  logic [ID_W-1:0]  b_id;
  always_comb begin
    b_found = 1'b0;
    b_win   = '0;
    b_id    = '0;
    for (int g = NGROUPS - 1; g >= 0; g--) begin
      if (grp_any_r[g]) begin
        b_found = 1'b1;
        b_win   = IDX_W'(g * GRP + int'(grp_lidx_r[g]));
        b_id    = grp_id_r[g];
      end
    end
  end

  // report byte: rising sensors within range, and the lowest pending one
  logic [7:0] in_rise;
  logic [2:0] pick;
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      in_rise[7-b] = in_data.sensor_byte[7-b] && !prev_r[in_data.byte_index][7-b]
                     && ((int'(in_data.byte_index) * 8 + b) < SENSORS);
    end
    pick = '0;
    for (int b = 7; b >= 0; b--) begin
      if (rise_r[7-b]) begin
        pick = 3'(b);
      end
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      for (int j = 0; j < REPORT_BYTES; j++) begin
        prev_r[j] <= '0;
      end
    end else begin
      if (out_valid_r && !out_stall && state_r != S_EMIT && state_r != S_ACK) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            mode_r <= in_data.func;
            key_r  <= in_data.waiter_id;
            mask_r <= {in_data.mask_word0, in_data.mask_word1, in_data.mask_word2[31:16]};
            idx_r  <= in_data.byte_index;
            case (in_data.func)
              FUNC_REPORT: begin
                if (int'(in_data.byte_index) >= REPORT_BYTES) begin
                  state_r <= S_ACK;
                end else begin
                  prev_r[in_data.byte_index] <= in_data.sensor_byte;
                  rise_r  <= in_rise;
                  state_r <= (in_rise == '0) ? S_ACK : S_SCAN;
                end
              end
              FUNC_REGISTER: begin
                if (int'(in_data.waiter_id) < WAITERS) begin
                  state_r <= S_MA;
                end
              end
              FUNC_REMOVE: state_r <= S_MA;
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_SCAN: begin
          sensor_r <= {idx_r, 3'b000} + SNS_W'(pick);
          rise_r   <= rise_r & ~(8'h80 >> pick);
          last_r   <= ((rise_r & ~(8'h80 >> pick)) == '0);
          state_r  <= S_MA;
        end
        S_MA: begin
          for (int g = 0; g < NGROUPS; g++) begin
            grp_any_r[g]  <= g_any[g];
            grp_lidx_r[g] <= g_lidx[g];
            grp_id_r[g]   <= g_id[g];
          end
          state_r <= S_MB;
        end
        S_MB: begin
          found_r <= b_found;
          win_r   <= b_win;
          wid_r   <= b_id;
          state_r <= S_REM;
        end
        S_REM: begin
          if (found_r) begin
            count_r <= count_r - 1'b1;
          end
          case (mode_r)
            FUNC_REPORT:   state_r <= S_EMIT;
            FUNC_REGISTER: state_r <= S_APP;
            default:       state_r <= S_ACK;
          endcase
        end
        S_APP: begin
          count_r <= count_r + 1'b1;
          state_r <= S_IDLE;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_data_r  <= '{kind: KIND_EVENT, sensor_number: sensor_r,
                             woken_valid: found_r,
                             woken_waiter: found_r ? wid_r : '0, last: last_r};
            state_r     <= last_r ? S_IDLE : S_SCAN;
          end
        end
        S_ACK: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_data_r  <= '{kind: KIND_ACK, sensor_number: '0, woken_valid: 1'b0,
                             woken_waiter: '0, last: 1'b1};
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(count_r) <= WAITERS)
    else $error("waiter count out of range");

  a_unlink: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REM && found_r) |=> count_r == $past(count_r) - 1'b1)
    else $error("matched waiter not unlinked");

  a_append: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_APP) |=> count_r == $past(count_r) + 1'b1)
    else $error("waiter not appended");

  a_win_in_chain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MB) |=> (!found_r || CNT_W'(win_r) < count_r))
    else $error("match outside the occupied chain");

endmodule
`default_nettype wire

@@ hdl/sewm_cell.sv @@
// one waiter slot of the insertion-ordered chain
`default_nettype none
module sewm_cell (
  input  wire                   clk,
  input  wire                   rst_n,
  input  sewm_pkg::cell_ctl_t   ctl,
  input  sewm_pkg::cell_data_t  nbr,
  input  sewm_pkg::cell_data_t  load_d,
  input  sewm_pkg::search_t     srch,
  output sewm_pkg::cell_data_t  cur,
  output logic                  hit
);
  import sewm_pkg::*;

  logic                 valid_r;
  logic [ID_W-1:0]      id_r;
  logic [0:MASK_BITS-1] mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.shift) begin
      valid_r <= nbr.valid;
    end else if (ctl.load) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      id_r   <= nbr.id;
      mask_r <= nbr.mask;
    end else if (ctl.load) begin
      id_r   <= load_d.id;
      mask_r <= load_d.mask;
    end
  end

  assign cur = '{valid: valid_r, id: id_r, mask: mask_r};

  always_comb begin
    if (srch.by_id) begin
      hit = valid_r && (id_r == srch.key);
    end else begin
      hit = valid_r && (32'(srch.sensor) < MASK_BITS) && mask_r[srch.sensor];
    end
  end

endmodule
`default_nettype wire

@@ verif/sewm_checker.sv @@
// checker for the sensor edge waiter matcher: predicts results and compares transfers
`timescale 1ns / 1ps
module sewm_checker (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  input  wire                 in_stall,
  input  sewm_pkg::in_item_t  in_data,
  input  wire                 out_valid,
  input  wire                 out_stall,
  input  sewm_pkg::out_item_t out_data,
  output int                  fail_count,
  output int                  pending
);
  import sewm_pkg::*;

  localparam logic [7:0] NO_WAITER = 8'hFF;

  logic [7:0]  prev_bytes [REPORT_BYTES];
  logic [79:0] wmask [WAITERS];
  logic [7:0]  wnext [WAITERS];
  logic [7:0]  wprev [WAITERS];
  logic        wlinked [WAITERS];
  logic [7:0]  head, tail;
  out_item_t   expected_q [$];

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic unlink(input int id);
    logic [7:0] p, n;
    p = wprev[id];
    n = wnext[id];
    if (p >= WAITERS) head = n; else wnext[p] = n;
    if (n >= WAITERS) tail = p; else wprev[n] = p;
    wlinked[id] = 1'b0;
  endtask

  task automatic push_result(input logic kind, input int s, input logic v,
                             input int w, input logic lst);
    out_item_t r;
    r.kind = kind;
    r.sensor_number = s[6:0];
    r.woken_valid = v;
    r.woken_waiter = w[6:0];
    r.last = lst;
    expected_q.push_back(r);
  endtask

  task automatic predict_item(input in_item_t it);
    int id, idx, s, cur, steps, cnt, who;
    logic [7:0] rise;
    logic hit;
    id = it.waiter_id;
    case (it.func)
      FUNC_REGISTER: begin
        if (wlinked[id]) unlink(id);
        wmask[id] = {it.mask_word0, it.mask_word1, it.mask_word2[31:16]};
        wnext[id] = NO_WAITER;
        wprev[id] = tail;
        if (tail >= WAITERS) head = id[7:0]; else wnext[tail] = id[7:0];
        tail = id[7:0];
        wlinked[id] = 1'b1;
      end
      FUNC_REMOVE: begin
        if (wlinked[id]) unlink(id);
        push_result(KIND_ACK, 0, 1'b0, 0, 1'b1);
      end
      FUNC_REPORT: begin
        idx = it.byte_index;
        if (idx >= REPORT_BYTES) begin
          push_result(KIND_ACK, 0, 1'b0, 0, 1'b1);
        end else begin
          rise = it.sensor_byte & ~prev_bytes[idx];
          prev_bytes[idx] = it.sensor_byte;
          cnt = 0;
          for (int b = 0; b < 8; b++) begin
            s = idx * 8 + b;
            if (rise[7 - b] && s < SENSORS) begin
              hit = 1'b0;
              who = 0;
              cur = head;
              steps = 0;
              while (steps < WAITERS && cur < WAITERS) begin
                if (wmask[cur][79 - s]) begin
                  hit = 1'b1;
                  who = cur;
                  unlink(cur);
                  break;
                end
                cur = wnext[cur];
                steps++;
              end
              push_result(KIND_EVENT, s, hit, who, 1'b0);
              cnt++;
            end
          end
          if (cnt == 0) push_result(KIND_ACK, 0, 1'b0, 0, 1'b1);
          else expected_q[expected_q.size() - 1].last = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    head = NO_WAITER;
    tail = NO_WAITER;
    foreach (prev_bytes[i]) prev_bytes[i] = '0;
    foreach (wlinked[i]) begin
      wlinked[i] = 1'b0;
      wmask[i] = '0;
      wnext[i] = '0;
      wprev[i] = '0;
    end
  end

  always @(posedge clk) begin
    out_item_t e;
    if (rst_n) begin
      if (in_valid && !in_stall) predict_item(in_data);
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result %p", out_data));
        end else begin
          e = expected_q.pop_front();
          if (out_data.kind !== e.kind)
            report_mismatch($sformatf("kind %0d exp %0d", out_data.kind, e.kind));
          if (out_data.sensor_number !== e.sensor_number)
            report_mismatch($sformatf("sensor %0d exp %0d",
                                      out_data.sensor_number, e.sensor_number));
          if (out_data.woken_valid !== e.woken_valid)
            report_mismatch($sformatf("woken_valid %0d exp %0d",
                                      out_data.woken_valid, e.woken_valid));
          if (out_data.woken_waiter !== e.woken_waiter)
            report_mismatch($sformatf("woken_waiter %0d exp %0d",
                                      out_data.woken_waiter, e.woken_waiter));
          if (out_data.last !== e.last)
            report_mismatch($sformatf("last %0d exp %0d", out_data.last, e.last));
        end
      end
    end
    pending = expected_q.size();
  end
endmodule

@@ verif/tb_sensor_edge_waiter_matcher.sv @@
// testbench top for the sensor edge waiter matcher: stimulus, idling and verdict
`timescale 1ns / 1ps
module tb_sensor_edge_waiter_matcher;
  import sewm_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  int        fail_count;
  int        pending;
  int        cycles;
  int        live_ids [$];
  in_item_t  stim_q [$];

  sensor_edge_waiter_matcher u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  sewm_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout");
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // receiver stall pattern: calm stretches, busy stretches
  initial begin
    int mode;
    out_stall = 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(5, 40)) begin
        @(posedge clk);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  function automatic in_item_t make_item(input logic [1:0] f, input int idx,
                                         input logic [7:0] b, input int id,
                                         input logic [95:0] m);
    in_item_t it;
    it.func = f;
    it.byte_index = idx[3:0];
    it.sensor_byte = b;
    it.waiter_id = id[6:0];
    {it.mask_word0, it.mask_word1, it.mask_word2} = m;
    return it;
  endfunction

  function automatic logic [95:0] rand_mask();
    logic [95:0] m;
    m = {$urandom, $urandom, $urandom};
    // sparse masks spread waiters out across sensors
    if ($urandom_range(0, 1)) m = m & {$urandom, $urandom, $urandom};
    return m;
  endfunction

  task automatic send(input in_item_t it);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic add_random();
    int r, id;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      id = $urandom_range(0, 127);
      stim_q.push_back(make_item(FUNC_REGISTER, 0, 8'($urandom), id, rand_mask()));
      live_ids.push_back(id);
    end else if (r < 50) begin
      if (live_ids.size() > 0 && $urandom_range(0, 1))
        id = live_ids[$urandom_range(0, live_ids.size() - 1)];
      else
        id = $urandom_range(0, 127);
      stim_q.push_back(make_item(FUNC_REMOVE, $urandom_range(0, 15), 8'($urandom), id,
                                 {$urandom, $urandom, $urandom}));
    end else if (r < 95) begin
      stim_q.push_back(make_item(FUNC_REPORT, $urandom_range(0, 9), 8'($urandom),
                                 $urandom, {$urandom, $urandom, $urandom}));
    end else if (r < 98) begin
      stim_q.push_back(make_item(FUNC_REPORT, $urandom_range(10, 15), 8'($urandom),
                                 $urandom, {$urandom, $urandom, $urandom}));
    end else begin
      stim_q.push_back(make_item(2'd3, $urandom, 8'($urandom), $urandom,
                                 {$urandom, $urandom, $urandom}));
    end
  endtask

  initial begin
    in_item_t it;
    int gap;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: full masks, ordering, re-register, remove, out of range, unused code
    stim_q.push_back(make_item(FUNC_REPORT, 0, 8'hFF, 0, '0));
    stim_q.push_back(make_item(FUNC_REGISTER, 0, 0, 0, {96{1'b1}}));
    stim_q.push_back(make_item(FUNC_REGISTER, 0, 0, 127, {96{1'b1}}));
    stim_q.push_back(make_item(FUNC_REGISTER, 0, 0, 5, 96'h8000_0000_0000_0000_0000_FFFF));
    stim_q.push_back(make_item(FUNC_REGISTER, 0, 0, 0, 96'h0000_0000_0000_0000_0001_0000));
    stim_q.push_back(make_item(FUNC_REPORT, 0, 8'h00, 0, '0));
    stim_q.push_back(make_item(FUNC_REPORT, 0, 8'hFF, 0, '0));
    stim_q.push_back(make_item(FUNC_REPORT, 9, 8'hFF, 0, '0));
    stim_q.push_back(make_item(FUNC_REPORT, 9, 8'h01, 0, '0));
    stim_q.push_back(make_item(FUNC_REPORT, 9, 8'h7F, 0, '0));
    stim_q.push_back(make_item(FUNC_REPORT, 10, 8'hFF, 0, '0));
    stim_q.push_back(make_item(FUNC_REPORT, 15, 8'hAA, 0, '0));
    stim_q.push_back(make_item(FUNC_REGISTER, 0, 0, 64, 96'hFFFF_FFFF_0000_0000_0000_0000));
    stim_q.push_back(make_item(FUNC_REGISTER, 0, 0, 65, 96'hFFFF_FFFF_0000_0000_0000_0000));
    stim_q.push_back(make_item(FUNC_REMOVE, 0, 0, 64, '0));
    stim_q.push_back(make_item(FUNC_REMOVE, 0, 0, 64, '0));
    stim_q.push_back(make_item(FUNC_REMOVE, 0, 0, 127, '0));
    stim_q.push_back(make_item(2'd3, 15, 8'hFF, 127, {96{1'b1}}));
    stim_q.push_back(make_item(FUNC_REPORT, 1, 8'h80, 0, '0));
    stim_q.push_back(make_item(FUNC_REPORT, 1, 8'h00, 0, '0));
    stim_q.push_back(make_item(FUNC_REPORT, 1, 8'h80, 0, '0));
    repeat (250) add_random();

    while (stim_q.size() > 0) begin
      repeat ($urandom_range(1, 12)) begin
        if (stim_q.size() == 0) break;
        it = stim_q.pop_front();
        send(it);
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    repeat (2) @(posedge clk);
    while (pending > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
